/* hw/rtl/spcp_pkg.sv */
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared widths, types and constants of the segment pair closest points unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spcp_pkg;

    // Coordinate format.
    localparam int CW        = 32;
    localparam int FB        = 16;
    localparam int NAXIS     = 3;
    localparam int NIN       = 4 * NAXIS;

    // Datapath widths.
    localparam int DW        = CW + 1;        // difference of two coordinates
    localparam int PW        = 2 * DW;        // product of two differences
    localparam int SUM_W     = PW + 2;        // dot product of two vectors
    localparam int HW        = SUM_W / 2;     // half of a dot product magnitude
    localparam int PPW       = 2 * HW;        // one partial product
    localparam int MW        = 2 * SUM_W;     // magnitude of a dot product product
    localparam int WW        = MW + 2;        // signed determinant and numerators
    localparam int Q_W       = FB + 1;        // parameter, Q0.FB with one included
    localparam int THR_W     = 32;
    localparam int THR_SHIFT = 4 * FB - 32;

    // Divider stages: sign and magnitude stage, clamp stage, one stage per bit.
    localparam int DIV_LAT   = FB + 2;

    // Stream widths.
    localparam int IN_TD_W   = ((NIN * CW + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 * NAXIS * CW + 2 * Q_W;
    localparam int OUT_TD_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [CW-1:0]    coord_t;
    typedef logic signed [DW-1:0]    diff_t;
    typedef logic signed [PW-1:0]    prod_t;
    typedef logic signed [SUM_W-1:0] dot_t;
    typedef logic        [SUM_W-1:0] mag_t;
    typedef logic        [PPW-1:0]   pp_t;
    typedef logic        [MW-1:0]    pmag_t;
    typedef logic signed [WW-1:0]    wide_t;
    typedef logic        [WW-1:0]    wmag_t;
    typedef logic        [Q_W-1:0]   q_t;

    localparam q_t Q_ONE = q_t'(1 << FB);

    // Start points and directions that ride along the pipeline.
    typedef struct packed {
        logic [NAXIS-1:0][CW-1:0] sa;
        logic [NAXIS-1:0][CW-1:0] sb;
        logic [NAXIS-1:0][DW-1:0] u;
        logic [NAXIS-1:0][DW-1:0] v;
    } side_t;

endpackage

`default_nettype wire

/* hw/rtl/segment_pair_closest_points_unit.sv */
// ----------------------------------------------------------------------------
// segment_pair_closest_points_unit
// Closest points between two 3D segments in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// The unit takes one segment pair per clock while s_tready is high and returns
// one result per pair, in order. Nine stages form the differences, the dot
// products, the exact determinant and the two numerators, eighteen stages run
// the two ratio dividers (sign and clamp checks, then one quotient bit per
// stage), two stages build and saturate the points, and one output register
// feeds the result port. The 16-step division sets the depth. A skid register
// behind the output keeps the pipeline from losing data when the result port
// stalls; s_tready only falls while the skid register is occupied. The
// near-parallel threshold is written on the configuration channel, which is
// always ready; the user must write it only while no transaction is in flight,
// and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_pair_closest_points_unit
    import spcp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THR_W-1:0]    cfg_data,      // parallel_threshold

    input  logic                s_tvalid,
    output logic                s_tready,
    // seg_a_start_x, y, z, seg_a_end_x, y, z, seg_b_start_x, y, z, seg_b_end_x, y, z
    input  logic [IN_TD_W-1:0]  s_tdata,

    output logic                m_tvalid,
    input  logic                m_tready,
    // near_a_x, y, z, near_b_x, y, z, param_a, param_b, zero fill
    output logic [OUT_TD_W-1:0] m_tdata
);

    localparam int FRONT    = 9;
    localparam int DIV_END  = FRONT + DIV_LAT - 1;
    localparam int MUL_IDX  = DIV_END + 1;
    localparam int END_IDX  = MUL_IDX + 1;
    localparam int NSTG     = END_IDX + 1;
    localparam int NPROD    = 6;
    localparam int MULT_W   = Q_W + 1 + DW;
    localparam int OFF_W    = MULT_W - FB;
    localparam int PT_W     = OFF_W + 1;

    // Wide product slots.
    localparam int P_AC = 0;
    localparam int P_BB = 1;
    localparam int P_BE = 2;
    localparam int P_CD = 3;
    localparam int P_AE = 4;
    localparam int P_BD = 5;

    typedef struct packed {
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] c;
        logic [SUM_W-1:0] d;
        logic [SUM_W-1:0] e;
        logic             b_gt_c;
    } par_t;

    logic [THR_W-1:0] thr_reg;

    logic  vld_reg  [NSTG];
    side_t side_reg [MUL_IDX+1];
    side_t side_next;
    diff_t w_next   [NAXIS];
    diff_t w_reg    [NAXIS];

    prod_t puu_reg [NAXIS];
    prod_t puv_reg [NAXIS];
    prod_t pvv_reg [NAXIS];
    prod_t puw_reg [NAXIS];
    prod_t pvw_reg [NAXIS];

    dot_t a_reg, b_reg, c_reg, d_reg, e_reg;

    mag_t ma_reg, mb_reg, mc_reg, md_reg, me_reg;
    logic neg_b_reg, neg_d_reg, neg_e_reg;
    par_t par_reg [3:7];

    mag_t  op_x [NPROD];
    mag_t  op_y [NPROD];
    logic  op_neg [NPROD];
    pp_t   pp_reg [NPROD][4];
    logic  pneg4_reg [NPROD];
    pmag_t pm_reg [NPROD];
    logic  pneg5_reg [NPROD];
    wide_t sp_reg [NPROD];

    wide_t det_reg, num_a_reg, num_b_reg;
    wmag_t lim;
    logic  is_par;
    wide_t ta_num_reg, ta_den_reg, tb_num_reg, tb_den_reg;

    q_t ta_quo, tb_quo;
    q_t ta27_reg, tb27_reg;
    logic signed [MULT_W-1:0] mp [2*NAXIS];
    logic [OFF_W-1:0]         off_reg [2*NAXIS];
    logic signed [PT_W-1:0]   pt [2*NAXIS];
    logic [CW-1:0]            pt_sat [2*NAXIS];
    logic [OUT_TD_W-1:0]      res_next;
    logic [OUT_TD_W-1:0]      res_reg;

    logic                pipe_en;
    logic                out_valid_reg;
    logic [OUT_TD_W-1:0] out_data_reg;
    logic                skid_valid_reg;
    logic [OUT_TD_W-1:0] skid_data_reg;

    assign cfg_ready = 1'b1;
    assign pipe_en   = !skid_valid_reg;
    assign s_tready  = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(4295);
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // Input unpacking and direction vectors.
    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            side_next.sa[i] = s_tdata[i*CW +: CW];
            side_next.sb[i] = s_tdata[(2*NAXIS+i)*CW +: CW];
            side_next.u[i]  = diff_t'($signed(s_tdata[(NAXIS+i)*CW +: CW]))
                            - diff_t'($signed(s_tdata[i*CW +: CW]));
            side_next.v[i]  = diff_t'($signed(s_tdata[(3*NAXIS+i)*CW +: CW]))
                            - diff_t'($signed(s_tdata[(2*NAXIS+i)*CW +: CW]));
            w_next[i]       = diff_t'($signed(s_tdata[i*CW +: CW]))
                            - diff_t'($signed(s_tdata[(2*NAXIS+i)*CW +: CW]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTG; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Wide product operands; the sign of each product comes from its factors.
    always_comb begin
        op_x[P_AC] = ma_reg;  op_y[P_AC] = mc_reg;  op_neg[P_AC] = 1'b0;
        op_x[P_BB] = mb_reg;  op_y[P_BB] = mb_reg;  op_neg[P_BB] = 1'b0;
        op_x[P_BE] = mb_reg;  op_y[P_BE] = me_reg;  op_neg[P_BE] = neg_b_reg ^ neg_e_reg;
        op_x[P_CD] = mc_reg;  op_y[P_CD] = md_reg;  op_neg[P_CD] = neg_d_reg;
        op_x[P_AE] = ma_reg;  op_y[P_AE] = me_reg;  op_neg[P_AE] = neg_e_reg;
        op_x[P_BD] = mb_reg;  op_y[P_BD] = md_reg;  op_neg[P_BD] = neg_b_reg ^ neg_d_reg;
    end

    assign lim    = wmag_t'(thr_reg) << THR_SHIFT;
    assign is_par = (det_reg == '0) || (wmag_t'(det_reg) < lim);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= MUL_IDX; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int i = 0; i < NAXIS; i++) begin
                w_reg[i]   <= w_next[i];
                puu_reg[i] <= $signed(side_reg[0].u[i]) * $signed(side_reg[0].u[i]);
                puv_reg[i] <= $signed(side_reg[0].u[i]) * $signed(side_reg[0].v[i]);
                pvv_reg[i] <= $signed(side_reg[0].v[i]) * $signed(side_reg[0].v[i]);
                puw_reg[i] <= $signed(side_reg[0].u[i]) * w_reg[i];
                pvw_reg[i] <= $signed(side_reg[0].v[i]) * w_reg[i];
            end

            a_reg <= dot_t'(puu_reg[0]) + dot_t'(puu_reg[1]) + dot_t'(puu_reg[2]);
            b_reg <= dot_t'(puv_reg[0]) + dot_t'(puv_reg[1]) + dot_t'(puv_reg[2]);
            c_reg <= dot_t'(pvv_reg[0]) + dot_t'(pvv_reg[1]) + dot_t'(pvv_reg[2]);
            d_reg <= dot_t'(puw_reg[0]) + dot_t'(puw_reg[1]) + dot_t'(puw_reg[2]);
            e_reg <= dot_t'(pvw_reg[0]) + dot_t'(pvw_reg[1]) + dot_t'(pvw_reg[2]);

            // Dot products of a vector with itself are never negative.
            ma_reg    <= mag_t'(a_reg);
            mc_reg    <= mag_t'(c_reg);
            mb_reg    <= b_reg[SUM_W-1] ? mag_t'(-b_reg) : mag_t'(b_reg);
            md_reg    <= d_reg[SUM_W-1] ? mag_t'(-d_reg) : mag_t'(d_reg);
            me_reg    <= e_reg[SUM_W-1] ? mag_t'(-e_reg) : mag_t'(e_reg);
            neg_b_reg <= b_reg[SUM_W-1];
            neg_d_reg <= d_reg[SUM_W-1];
            neg_e_reg <= e_reg[SUM_W-1];
            par_reg[3] <= '{b: b_reg, c: c_reg, d: d_reg, e: e_reg, b_gt_c: (b_reg > c_reg)};
            for (int k = 4; k <= 7; k++) begin
                par_reg[k] <= par_reg[k-1];
            end

            for (int p = 0; p < NPROD; p++) begin
                pp_reg[p][0] <= pp_t'(op_x[p][HW-1:0])  * pp_t'(op_y[p][HW-1:0]);
                pp_reg[p][1] <= pp_t'(op_x[p][HW-1:0])  * pp_t'(op_y[p][2*HW-1:HW]);
                pp_reg[p][2] <= pp_t'(op_x[p][2*HW-1:HW]) * pp_t'(op_y[p][HW-1:0]);
                pp_reg[p][3] <= pp_t'(op_x[p][2*HW-1:HW]) * pp_t'(op_y[p][2*HW-1:HW]);
                pneg4_reg[p] <= op_neg[p];

                pm_reg[p]    <= pmag_t'(pp_reg[p][0])
                              + ((pmag_t'(pp_reg[p][1]) + pmag_t'(pp_reg[p][2])) << HW)
                              + (pmag_t'(pp_reg[p][3]) << (2 * HW));
                pneg5_reg[p] <= pneg4_reg[p];

                sp_reg[p]    <= pneg5_reg[p] ? -$signed({2'b00, pm_reg[p]})
                                             :  $signed({2'b00, pm_reg[p]});
            end

            det_reg   <= sp_reg[P_AC] - sp_reg[P_BB];
            num_a_reg <= sp_reg[P_BE] - sp_reg[P_CD];
            num_b_reg <= sp_reg[P_AE] - sp_reg[P_BD];

            // Near-parallel: TA is zero and TB projects onto the longer divisor.
            if (is_par) begin
                ta_num_reg <= '0;
                ta_den_reg <= '0;
                if (par_reg[7].b_gt_c) begin
                    tb_num_reg <= wide_t'($signed(par_reg[7].d));
                    tb_den_reg <= wide_t'($signed(par_reg[7].b));
                end else begin
                    tb_num_reg <= wide_t'($signed(par_reg[7].e));
                    tb_den_reg <= wide_t'($signed(par_reg[7].c));
                end
            end else begin
                ta_num_reg <= num_a_reg;
                ta_den_reg <= det_reg;
                tb_num_reg <= num_b_reg;
                tb_den_reg <= det_reg;
            end

            ta27_reg <= ta_quo;
            tb27_reg <= tb_quo;
            for (int i = 0; i < NAXIS; i++) begin
                off_reg[i]       <= mp[i][MULT_W-1:FB];
                off_reg[NAXIS+i] <= mp[NAXIS+i][MULT_W-1:FB];
            end

            res_reg  <= res_next;
        end
    end

    spcp_div u_div_a (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (ta_num_reg),
        .den  (ta_den_reg),
        .quo  (ta_quo)
    );

    spcp_div u_div_b (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (tb_num_reg),
        .den  (tb_den_reg),
        .quo  (tb_quo)
    );

    // Point offsets: parameter times direction, floored to FB fractional bits.
    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            mp[i]       = $signed({2'b00, ta_quo}) * $signed(side_reg[DIV_END].u[i]);
            mp[NAXIS+i] = $signed({2'b00, tb_quo}) * $signed(side_reg[DIV_END].v[i]);
        end
    end

    // Point sums with saturation to the coordinate range.
    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            pt[i]       = PT_W'($signed(side_reg[MUL_IDX].sa[i])) + PT_W'($signed(off_reg[i]));
            pt[NAXIS+i] = PT_W'($signed(side_reg[MUL_IDX].sb[i]))
                        + PT_W'($signed(off_reg[NAXIS+i]));
        end
        for (int j = 0; j < 2 * NAXIS; j++) begin
            if (!pt[j][PT_W-1] && (pt[j][PT_W-1:CW-1] != '0)) begin
                pt_sat[j] = {1'b0, {(CW-1){1'b1}}};
            end else if (pt[j][PT_W-1] && (pt[j][PT_W-1:CW-1] != '1)) begin
                pt_sat[j] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                pt_sat[j] = pt[j][CW-1:0];
            end
        end
        res_next = '0;
        for (int j = 0; j < 2 * NAXIS; j++) begin
            res_next[j*CW +: CW] = pt_sat[j];
        end
        res_next[2*NAXIS*CW +: Q_W]       = ta27_reg;
        res_next[2*NAXIS*CW + Q_W +: Q_W] = tb27_reg;
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (!out_valid_reg || m_tready) begin
                out_valid_reg <= vld_reg[END_IDX];
            end else if (vld_reg[END_IDX]) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_data_reg <= res_reg;
        end else begin
            skid_data_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The skid register only fills behind a stalled output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A stalled output with a new result arriving must park it in the skid register.
    a_skid_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[END_IDX] && !skid_valid_reg && out_valid_reg && !m_tready)
        |=> skid_valid_reg)
        else $error("result dropped at a stalled output");

    // When the output drains with the skid register full, the skid result comes next.
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (out_data_reg == $past(skid_data_reg)))
        else $error("skid result not forwarded in order");

    // Parameters never exceed one.
    a_param_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2*NAXIS*CW +: Q_W] <= Q_ONE)
                   && (m_tdata[2*NAXIS*CW + Q_W +: Q_W] <= Q_ONE)))
        else $error("parameter above one");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!out_valid_reg && !skid_valid_reg))
        else $error("output not empty after reset");

endmodule

`default_nettype wire

/* hw/rtl/spcp_div.sv */
// ----------------------------------------------------------------------------
// spcp_div
// Pipelined ratio unit: num/den truncated to Q0.FB and clamped to [0, 1].
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_div
    import spcp_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  wide_t num,
    input  wide_t den,
    output q_t    quo
);

    logic  zero0_reg;
    wmag_t n0_reg;
    wmag_t m0_reg;

    logic  zero1_reg;
    logic  one1_reg;
    wmag_t n1_reg;
    wmag_t m1_reg;

    wmag_t         st_n_reg    [FB];
    wmag_t         st_m_reg    [FB];
    logic [FB-1:0] st_q_reg    [FB];
    logic          st_zero_reg [FB];
    logic          st_one_reg  [FB];

    wmag_t         st_src_n  [FB];
    wmag_t         st_src_m  [FB];
    logic [FB-1:0] st_src_q  [FB];
    wmag_t         st_sh     [FB];
    wmag_t         st_n_next [FB];
    logic [FB-1:0] st_q_next [FB];

    // One restoring division step per stage.
    always_comb begin
        for (int k = 0; k < FB; k++) begin
            st_src_n[k] = (k == 0) ? n1_reg : st_n_reg[(k == 0) ? 0 : k - 1];
            st_src_m[k] = (k == 0) ? m1_reg : st_m_reg[(k == 0) ? 0 : k - 1];
            st_src_q[k] = (k == 0) ? '0     : st_q_reg[(k == 0) ? 0 : k - 1];
            st_sh[k]    = st_src_n[k] << 1;
            if (st_sh[k] >= st_src_m[k]) begin
                st_n_next[k] = st_sh[k] - st_src_m[k];
                st_q_next[k] = {st_src_q[k][FB-2:0], 1'b1};
            end else begin
                st_n_next[k] = st_sh[k];
                st_q_next[k] = {st_src_q[k][FB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // A zero operand or opposite signs give a parameter of zero.
            zero0_reg <= (den == '0) || (num == '0) || (num[WW-1] != den[WW-1]);
            n0_reg    <= num[WW-1] ? wmag_t'(-num) : wmag_t'(num);
            m0_reg    <= den[WW-1] ? wmag_t'(-den) : wmag_t'(den);

            zero1_reg <= zero0_reg;
            one1_reg  <= (n0_reg >= m0_reg);
            n1_reg    <= n0_reg;
            m1_reg    <= m0_reg;

            for (int k = 0; k < FB; k++) begin
                st_n_reg[k]    <= st_n_next[k];
                st_m_reg[k]    <= st_src_m[k];
                st_q_reg[k]    <= st_q_next[k];
                st_zero_reg[k] <= (k == 0) ? zero1_reg : st_zero_reg[(k == 0) ? 0 : k - 1];
                st_one_reg[k]  <= (k == 0) ? one1_reg  : st_one_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign quo = st_zero_reg[FB-1] ? q_t'(0) :
                 st_one_reg[FB-1]  ? Q_ONE   : {1'b0, st_q_reg[FB-1]};

endmodule

`default_nettype wire
